@@ rtl/ipcd_pkg.sv @@
// ipcd_pkg: shared types, constants and the quarter-wave sine polynomial
// used by every module of the inverse park/clarke duty pipeline
// no dependencies
package ipcd_pkg;

	localparam int SUP_W  = 16;
	localparam int VOLT_W = 50;
	localparam int FRAC_W = 32;
	localparam int OUT_W  = 11;

	localparam logic [15:0] SUPPLY_RESET = 16'd3072;

	localparam logic [63:0] POLY_A1 = 64'd51472;
	localparam logic [63:0] POLY_A3 = 64'd21024;
	localparam logic [63:0] POLY_A5 = 64'd2320;
	localparam logic [63:0] SINE_CAP = 64'd32767;

	localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

	typedef logic signed [15:0] q15_t;
	typedef logic signed [VOLT_W-1:0] volt_t;
	typedef logic [16:0] zpos_t;
	typedef logic [14:0] qsin_t;
	typedef logic [OUT_W-1:0] duty_t;

	typedef struct packed {
		logic zero;
		logic full;
	} clamp_t;

	// sin(pi/2 * z), z in q15 from 0 to 32768, capped at 32767
	function automatic qsin_t quarter_sine(input zpos_t z);
		logic [63:0] zz;
		logic [63:0] z2;
		logic [63:0] t;
		logic [63:0] s;
		zz = 64'(z);
		z2 = (zz * zz) >> 15;
		t = POLY_A3 - ((z2 * POLY_A5) >> 15);
		t = POLY_A1 - ((z2 * t) >> 15);
		s = (zz * t) >> 15;
		if (s > SINE_CAP) begin
			s = SINE_CAP;
		end
		return s[14:0];
	endfunction

endpackage

@@ rtl/ipcd_sincos.sv @@
// ipcd_sincos: stage 1, angle to table index, sine and cosine lookup
// depends on ipcd_pkg; quarter-wave table built at elaboration
module ipcd_sincos #(
	parameter int ANGLE_BITS      = 16,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [15:0]    quad_voltage,
	input  logic [ANGLE_BITS-1:0] elec_angle,
	output ipcd_pkg::q15_t        uq_s1,
	output ipcd_pkg::q15_t        sin_s1,
	output ipcd_pkg::q15_t        cos_s1
);

	localparam int STB     = SINE_TABLE_BITS;
	localparam int QUARTER = 2 ** (STB - 2);
	localparam int ZSHIFT  = 17 - STB;
	localparam logic [STB-2:0] QUARTER_V = (STB - 1)'(QUARTER);

	typedef ipcd_pkg::qsin_t qtab_t [QUARTER+1];

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int i = 0; i <= QUARTER; i++) begin
			t[i] = ipcd_pkg::quarter_sine(ipcd_pkg::zpos_t'(i << ZSHIFT));
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	function automatic ipcd_pkg::q15_t lookup(input logic [1:0] quad,
		input logic [STB-3:0] r);
		logic [STB-2:0] pos;
		ipcd_pkg::q15_t val;
		pos = quad[0] ? (QUARTER_V - {1'b0, r}) : {1'b0, r};
		val = {1'b0, QTAB[pos]};
		return quad[1] ? -val : val;
	endfunction

	logic [STB-1:0] k;
	logic [1:0]     quad_sin;
	logic [1:0]     quad_cos;
	logic [STB-3:0] rem_idx;

	if (ANGLE_BITS >= SINE_TABLE_BITS) begin : g_idx_shr
		assign k = elec_angle[ANGLE_BITS-1 -: STB];
	end else begin : g_idx_shl
		assign k = {elec_angle, {(STB - ANGLE_BITS){1'b0}}};
	end

	assign quad_sin = k[STB-1:STB-2];
	assign quad_cos = quad_sin + 2'd1;
	assign rem_idx  = k[STB-3:0];

	always_ff @(posedge clk) begin
		if (en) begin
			uq_s1  <= quad_voltage;
			sin_s1 <= lookup(quad_sin, rem_idx);
			cos_s1 <= lookup(quad_cos, rem_idx);
		end
	end

endmodule

@@ rtl/ipcd_phase.sv @@
// ipcd_phase: stages 2 to 4, inverse park products and inverse clarke sums
// depends on ipcd_pkg; phase voltages come out at scale 2^40
module ipcd_phase (
	input  logic                              clk,
	input  logic [2:0]                        en,
	input  logic [ipcd_pkg::SUP_W-1:0]        supply,
	input  ipcd_pkg::q15_t                    uq_s1,
	input  ipcd_pkg::q15_t                    sin_s1,
	input  ipcd_pkg::q15_t                    cos_s1,
	output ipcd_pkg::volt_t                   ua_s4,
	output ipcd_pkg::volt_t                   ub_s4,
	output ipcd_pkg::volt_t                   uc_s4
);

	logic signed [31:0] p_s2;
	logic signed [31:0] q_s2;
	logic signed [31:0] p_s3;
	ipcd_pkg::volt_t    s3q_s3;
	ipcd_pkg::volt_t    pe;
	ipcd_pkg::volt_t    half;

	assign pe   = ipcd_pkg::volt_t'(p_s3);
	assign half = ipcd_pkg::volt_t'({supply, 31'b0});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s2 <= uq_s1 * sin_s1;
			q_s2 <= uq_s1 * cos_s1;
		end
		if (en[1]) begin
			p_s3   <= p_s2;
			s3q_s3 <= ipcd_pkg::volt_t'(q_s2) * ipcd_pkg::SQRT3_Q16;
		end
		if (en[2]) begin
			ua_s4 <= half - (pe <<< 17);
			ub_s4 <= s3q_s3 + (pe <<< 16) + half;
			uc_s4 <= (pe <<< 16) - s3q_s3 + half;
		end
	end

endmodule

@@ rtl/ipcd_scale.sv @@
// ipcd_scale: stages 5 and 6 for one phase, clamp decision and duty scaling
// depends on ipcd_pkg; result is the dividend for ipcd_div
module ipcd_scale #(
	parameter int DUTY_FULL = 2047,
	parameter int DW        = 11
) (
	input  logic                                clk,
	input  logic [1:0]                          en,
	input  logic [ipcd_pkg::SUP_W-1:0]          supply,
	input  ipcd_pkg::volt_t                     u_s4,
	output logic [ipcd_pkg::SUP_W+DW-1:0]       n_s6,
	output ipcd_pkg::clamp_t                    clamp_s6
);

	localparam int NW = ipcd_pkg::SUP_W + DW;
	localparam int FW = ipcd_pkg::FRAC_W;
	localparam logic [DW-1:0] DF_V = DW'(DUTY_FULL);

	logic [ipcd_pkg::VOLT_W-2:0] full_ref;
	logic [FW+DW-1:0]            lo_prod;
	ipcd_pkg::clamp_t            clamp_c;
	logic [NW-1:0]               hi_s5;
	logic [DW-1:0]               lo_s5;
	ipcd_pkg::clamp_t            clamp_s5;

	assign full_ref      = {1'b0, supply, {FW{1'b0}}};
	assign clamp_c.zero  = (supply == '0) || u_s4[ipcd_pkg::VOLT_W-1] || (u_s4 == '0);
	assign clamp_c.full  = u_s4[ipcd_pkg::VOLT_W-2:0] >= full_ref;
	assign lo_prod       = u_s4[FW-1:0] * DF_V;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			hi_s5    <= u_s4[FW+ipcd_pkg::SUP_W-1:FW] * DF_V;
			lo_s5    <= lo_prod[FW+DW-1:FW];
			clamp_s5 <= clamp_c;
		end
		if (en[1]) begin
			n_s6     <= hi_s5 + NW'(lo_s5);
			clamp_s6 <= clamp_s5;
		end
	end

endmodule

@@ rtl/ipcd_div.sv @@
// ipcd_div: restoring divider, one quotient bit per stage, with clamp merge
// depends on ipcd_pkg; divides the scaled phase value by the supply
module ipcd_div #(
	parameter int DUTY_FULL = 2047,
	parameter int DW        = 11
) (
	input  logic                           clk,
	input  logic [DW-1:0]                  en,
	input  logic [ipcd_pkg::SUP_W-1:0]     supply,
	input  logic [ipcd_pkg::SUP_W+DW-1:0]  n_s6,
	input  ipcd_pkg::clamp_t               clamp_s6,
	output logic [DW-1:0]                  duty_q
);

	localparam int NW = ipcd_pkg::SUP_W + DW;
	localparam logic [DW-1:0] DF_V = DW'(DUTY_FULL);

	logic [NW-1:0]    rem_s   [DW-1];
	logic [DW-1:0]    quo_s   [DW-1];
	ipcd_pkg::clamp_t clamp_s [DW-1];

	for (genvar j = 0; j < DW; j++) begin : g_stage
		localparam logic [DW-1:0] QBIT = DW'(1) << (DW - 1 - j);

		logic [NW-1:0]    r_in;
		logic [DW-1:0]    q_in;
		ipcd_pkg::clamp_t c_in;
		logic [NW-1:0]    trial;
		logic             ge;

		if (j == 0) begin : g_first
			assign r_in = n_s6;
			assign q_in = '0;
			assign c_in = clamp_s6;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign q_in = quo_s[j-1];
			assign c_in = clamp_s[j-1];
		end

		assign trial = NW'(supply) << (DW - 1 - j);
		assign ge    = r_in >= trial;

		if (j < DW - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j]   <= ge ? (r_in - trial) : r_in;
					quo_s[j]   <= ge ? (q_in | QBIT) : q_in;
					clamp_s[j] <= c_in;
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (en[j]) begin
					if (c_in.zero) begin
						duty_q <= '0;
					end else if (c_in.full) begin
						duty_q <= DF_V;
					end else begin
						duty_q <= ge ? (q_in | QBIT) : q_in;
					end
				end
			end
		end
	end

endmodule

@@ rtl/inverse_park_clarke_duty.sv @@
// inverse_park_clarke_duty: top level, stage valids, stall network, supply register
// depends on ipcd_pkg, ipcd_sincos, ipcd_phase, ipcd_scale, ipcd_div
//
// channel | dir | handshake             | payload
// input   | in  | in_valid / in_stall   | quad_voltage, elec_angle
// output  | out | out_valid / out_stall | duty_a, duty_b, duty_c
// config  | in  | cfg_valid / cfg_ready | supply_voltage
//
// one item per cycle while in_stall is low; the restoring divider at the end
// resolves one duty bit per stage
// reset clears every stage valid and loads supply 3072 (12 V in q8.8)
// a stage holds its item while the stage after it is full and stalled; empty
// stages close up, so in_stall rises only with every stage full and out_stall high
module inverse_park_clarke_duty #(
	parameter int ANGLE_BITS      = 16,
	parameter int SINE_TABLE_BITS = 10,
	parameter int DUTY_FULL       = 2047
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [15:0]            quad_voltage,
	input  logic [ANGLE_BITS-1:0]         elec_angle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ipcd_pkg::duty_t               duty_a,
	output ipcd_pkg::duty_t               duty_b,
	output ipcd_pkg::duty_t               duty_c,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ipcd_pkg::SUP_W-1:0]    supply_voltage
);

	localparam int DW           = $clog2(DUTY_FULL + 1);
	localparam int NW           = ipcd_pkg::SUP_W + DW;
	localparam int FRONT_STAGES = 6;
	localparam int L            = FRONT_STAGES + DW;
	localparam logic [DW-1:0] DF_V = DW'(DUTY_FULL);

	logic [ipcd_pkg::SUP_W-1:0] supply_q;
	logic [L:1]                 vld_q;
	logic [L:1]                 prev_vld;
	logic [L:1]                 adv;

	ipcd_pkg::q15_t   uq_s1;
	ipcd_pkg::q15_t   sin_s1;
	ipcd_pkg::q15_t   cos_s1;
	ipcd_pkg::volt_t  u_s4 [3];
	logic [NW-1:0]    n_s6 [3];
	ipcd_pkg::clamp_t clamp_s6 [3];
	logic [DW-1:0]    duty_w [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= ipcd_pkg::SUPPLY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			supply_q <= supply_voltage;
		end
	end

	// a stage may load when out_stall is low or when it or any stage after it is empty
	for (genvar i = 1; i <= L; i++) begin : g_adv
		assign adv[i] = !out_stall || !(&vld_q[L:i]);
	end

	assign prev_vld  = {vld_q[L-1:1], in_valid};
	assign in_stall  = !adv[1];
	assign out_valid = vld_q[L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= L; i++) begin
				if (adv[i]) begin
					vld_q[i] <= prev_vld[i];
				end
			end
		end
	end

	ipcd_sincos #(
		.ANGLE_BITS      (ANGLE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_sincos (
		.clk          (clk),
		.en           (adv[1]),
		.quad_voltage (quad_voltage),
		.elec_angle   (elec_angle),
		.uq_s1        (uq_s1),
		.sin_s1       (sin_s1),
		.cos_s1       (cos_s1)
	);

	ipcd_phase u_phase (
		.clk    (clk),
		.en     (adv[4:2]),
		.supply (supply_q),
		.uq_s1  (uq_s1),
		.sin_s1 (sin_s1),
		.cos_s1 (cos_s1),
		.ua_s4  (u_s4[0]),
		.ub_s4  (u_s4[1]),
		.uc_s4  (u_s4[2])
	);

	for (genvar ph = 0; ph < 3; ph++) begin : g_phase
		ipcd_scale #(
			.DUTY_FULL (DUTY_FULL),
			.DW        (DW)
		) u_scale (
			.clk      (clk),
			.en       (adv[6:5]),
			.supply   (supply_q),
			.u_s4     (u_s4[ph]),
			.n_s6     (n_s6[ph]),
			.clamp_s6 (clamp_s6[ph])
		);

		ipcd_div #(
			.DUTY_FULL (DUTY_FULL),
			.DW        (DW)
		) u_div (
			.clk      (clk),
			.en       (adv[L:FRONT_STAGES+1]),
			.supply   (supply_q),
			.n_s6     (n_s6[ph]),
			.clamp_s6 (clamp_s6[ph]),
			.duty_q   (duty_w[ph])
		);
	end

	assign duty_a = ipcd_pkg::duty_t'(duty_w[0]);
	assign duty_b = ipcd_pkg::duty_t'(duty_w[1]);
	assign duty_c = ipcd_pkg::duty_t'(duty_w[2]);

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q))
		else $error("input stalled while a pipeline stage is empty");

	a_stall_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_stall)
		else $error("input stalled without an output stall");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_w[0] <= DF_V) && (duty_w[1] <= DF_V) && (duty_w[2] <= DF_V))
		else $error("duty above full scale");

endmodule
